[rtl/next_permutation_engine_macros.svh]
// Assertion macros for the next permutation engine checker.
// Depends on nothing; included by the checker file.
`ifndef NEXT_PERMUTATION_ENGINE_MACROS_SVH
`define NEXT_PERMUTATION_ENGINE_MACROS_SVH

// Clocked assertion, off while reset is high.
`define NPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/npe_pkg.sv]
// Shared types and constants for the next permutation engine.
// No dependencies; imported by every module of the block.
package npe_pkg;

  localparam int MAX_LENGTH     = 16;
  localparam int VALUE_BITS     = 8;
  localparam int MAX_RESULTS    = 16;
  localparam int IDX_BITS       = $clog2(MAX_LENGTH);
  localparam int LEN_BITS       = 5;
  localparam int POS_BITS       = 4;
  localparam int OUT_VALUE_BITS = 8;
  localparam int LEN_RESET      = 16;

  typedef logic [VALUE_BITS-1:0] elem_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } npe_cmd_code_t;

  typedef struct packed {
    npe_cmd_code_t               cmd;
    logic [POS_BITS-1:0]         position;
    logic [OUT_VALUE_BITS-1:0]   value;
  } npe_req_t;

  typedef struct packed {
    logic [POS_BITS-1:0]         out_position;
    logic [OUT_VALUE_BITS-1:0]   out_value;
    logic                        advanced;
    logic                        last;
  } npe_res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_RD_PIV,
    OP_DEC_I,
    OP_PIVOT_SAVE,
    OP_RD_SUC,
    OP_DEC_J,
    OP_SWAP_A,
    OP_SWAP_B,
    OP_RD_REV,
    OP_REV_A,
    OP_REV_B,
    OP_EMIT
  } npe_op_t;

  typedef struct packed {
    logic len_zero;
    logic i_zero;
    logic piv_ge;
    logic suc_stop;
    logic rev_done;
    logic emit_last;
  } npe_status_t;

endpackage

[rtl/npe_datapath.sv]
// Datapath: element memory, scan/swap index registers, compare status.
// Depends on npe_pkg; driven by npe_ctrl through npe_op_t.
module npe_datapath import npe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  npe_op_t             op,
  input  npe_req_t            request,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_data,
  output npe_status_t         status,
  output npe_res_t            result
);

  elem_t mem [MAX_LENGTH];

  logic [LEN_BITS-1:0] len_cfg;
  logic [LEN_BITS-1:0] act_len;
  logic [LEN_BITS-1:0] emit_cnt;
  logic [LEN_BITS-1:0] len_m1;
  logic [LEN_BITS-1:0] cnt_m1;

  logic [IDX_BITS-1:0] i;
  logic [IDX_BITS-1:0] j;
  logic [IDX_BITS-1:0] k;
  logic [IDX_BITS-1:0] out_pos;
  elem_t               pv;
  elem_t               qa;
  elem_t               qb;
  logic                adv;
  logic                out_last;

  logic [IDX_BITS-1:0] ra;
  logic [IDX_BITS-1:0] rb;
  logic                rd_en;
  logic [IDX_BITS-1:0] wa;
  elem_t               wd;
  logic                we;

  assign act_len  = (len_cfg > LEN_BITS'(MAX_LENGTH)) ? LEN_BITS'(MAX_LENGTH) : len_cfg;
  assign emit_cnt = (act_len > LEN_BITS'(MAX_RESULTS)) ? LEN_BITS'(MAX_RESULTS) : act_len;
  assign len_m1   = act_len - 1'b1;
  assign cnt_m1   = emit_cnt - 1'b1;

  assign status.len_zero  = (act_len == '0);
  assign status.i_zero    = (i == '0);
  assign status.piv_ge    = (qa >= qb);
  assign status.suc_stop  = (j == i) || (qb > pv);
  assign status.rev_done  = !(i < j);
  assign status.emit_last = (LEN_BITS'(k) == cnt_m1);

  assign result.out_position = POS_BITS'(out_pos);
  assign result.out_value    = OUT_VALUE_BITS'(qa);
  assign result.advanced     = adv;
  assign result.last         = out_last;

  always_comb begin
    ra    = i;
    rb    = j;
    rd_en = 1'b0;
    we    = 1'b0;
    wa    = i;
    wd    = qb;
    case (op)
      OP_LOAD: begin
        we = (32'(request.position) < MAX_LENGTH);
        wa = IDX_BITS'(request.position);
        wd = VALUE_BITS'(request.value);
      end
      OP_RD_PIV: begin
        ra    = i - 1'b1;
        rb    = i;
        rd_en = 1'b1;
      end
      OP_RD_SUC: rd_en = 1'b1;
      OP_RD_REV: rd_en = 1'b1;
      OP_EMIT: begin
        ra    = k;
        rd_en = 1'b1;
      end
      OP_SWAP_A: begin
        we = 1'b1;
        wa = i - 1'b1;
        wd = qb;
      end
      OP_SWAP_B: begin
        we = 1'b1;
        wa = j;
        wd = pv;
      end
      OP_REV_A: begin
        we = 1'b1;
        wa = i;
        wd = qb;
      end
      OP_REV_B: begin
        we = 1'b1;
        wa = j;
        wd = qa;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      qa <= mem[ra];
      qb <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg <= LEN_BITS'(LEN_RESET);
    end else if (cfg_we) begin
      len_cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_INIT: begin
        i   <= len_m1[IDX_BITS-1:0];
        k   <= '0;
        adv <= 1'b0;
      end
      OP_DEC_I: i <= i - 1'b1;
      OP_PIVOT_SAVE: begin
        pv <= qa;
        j  <= len_m1[IDX_BITS-1:0];
      end
      OP_DEC_J:  j   <= j - 1'b1;
      OP_SWAP_A: adv <= 1'b1;
      OP_SWAP_B: j   <= len_m1[IDX_BITS-1:0];
      OP_REV_B: begin
        i <= i + 1'b1;
        j <= j - 1'b1;
      end
      OP_EMIT: begin
        out_pos  <= k;
        out_last <= status.emit_last;
        k        <= k + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/npe_ctrl.sv]
// Controller: sequences pivot scan, successor scan, swap, reversal, emit.
// Depends on npe_pkg; drives npe_datapath through npe_op_t.
module npe_ctrl import npe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  npe_cmd_code_t req_cmd,
  input  npe_status_t   status,
  output npe_op_t       op,
  output logic          busy,
  output logic          result_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_RD,
    S_P_CMP,
    S_S_RD,
    S_S_CMP,
    S_SW_A,
    S_SW_B,
    S_R_RD,
    S_R_WA,
    S_R_WB,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req_cmd == CMD_LOAD) begin
            op = OP_LOAD;
          end else if (!status.len_zero) begin
            op         = OP_INIT;
            state_next = S_P_RD;
          end
        end
      end
      S_P_RD: begin
        if (status.i_zero) begin
          state_next = S_EMIT;
        end else begin
          op         = OP_RD_PIV;
          state_next = S_P_CMP;
        end
      end
      S_P_CMP: begin
        if (status.piv_ge) begin
          op         = OP_DEC_I;
          state_next = S_P_RD;
        end else begin
          op         = OP_PIVOT_SAVE;
          state_next = S_S_RD;
        end
      end
      S_S_RD: begin
        op         = OP_RD_SUC;
        state_next = S_S_CMP;
      end
      S_S_CMP: begin
        if (status.suc_stop) begin
          state_next = S_SW_A;
        end else begin
          op         = OP_DEC_J;
          state_next = S_S_RD;
        end
      end
      S_SW_A: begin
        op         = OP_SWAP_A;
        state_next = S_SW_B;
      end
      S_SW_B: begin
        op         = OP_SWAP_B;
        state_next = S_R_RD;
      end
      S_R_RD: begin
        if (status.rev_done) begin
          state_next = S_EMIT;
        end else begin
          op         = OP_RD_REV;
          state_next = S_R_WA;
        end
      end
      S_R_WA: begin
        op         = OP_REV_A;
        state_next = S_R_WB;
      end
      S_R_WB: begin
        op         = OP_REV_B;
        state_next = S_R_RD;
      end
      S_EMIT: begin
        op = OP_EMIT;
        if (status.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_EMIT);
    end
  end

endmodule

[rtl/next_permutation_engine.sv]
// Lexicographic next-permutation engine, top level.
// Depends on npe_pkg, npe_ctrl and npe_datapath.
//
// A load request (cmd = 0) writes one element; busy stays low. An advance
// request (cmd = 1) rewrites the first length_in_use elements into their
// lexicographic successor, if one exists, and then emits them in index order,
// one per cycle, on result with result_valid high; the receiver cannot stall,
// so results must be taken as they appear. Elements live in a 16 x 8 memory
// with two registered read ports and one write port: each pivot or successor
// scan step reads and then compares, the swap writes its two elements in
// turn, and each reversed pair is read and then written back one element at
// a time. The length in use is capped at 16. The final result is shown in
// the first cycle with busy low, and a new request is taken in that cycle.
// An advance with length zero emits nothing and leaves the engine idle.
module next_permutation_engine import npe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  npe_req_t            request,
  output logic                result_valid,
  output npe_res_t            result,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_data
);

  npe_op_t     op;
  npe_status_t status;

  npe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_cmd      (request.cmd),
    .status       (status),
    .op           (op),
    .busy         (busy),
    .result_valid (result_valid)
  );

  npe_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .status   (status),
    .result   (result)
  );

endmodule

[rtl/npe_checker.sv]
// Port-level checker for the next permutation engine, bound to the top level.
// Depends on npe_pkg and next_permutation_engine_macros.svh.
`include "next_permutation_engine_macros.svh"

module npe_checker import npe_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input npe_req_t request,
  input logic     result_valid,
  input npe_res_t result
);

  `NPE_ASSERT(a_run_busy, result_valid && !result.last |-> busy, "run ended without last")
  `NPE_ASSERT(a_run_contig, result_valid && !result.last |=> result_valid, "gap in result run")
  `NPE_ASSERT(a_pos_step,
    result_valid && !result.last |=>
      result.out_position == 4'($past(result.out_position) + 4'd1),
    "position not in order")
  `NPE_ASSERT(a_adv_same,
    result_valid && !result.last |=> result.advanced == $past(result.advanced),
    "advanced flag changed in run")
  `NPE_ASSERT(a_load_quiet,
    start && !busy && request.cmd == CMD_LOAD |=> !result_valid,
    "load request produced a result")

endmodule

bind next_permutation_engine npe_checker u_npe_checker (.*);

[tb/tb_next_permutation_engine.sv]
// Self-checking testbench for next_permutation_engine: loads, advances and length changes
// are checked against a predictor of the lexicographic successor, field by field.
// Depends on npe_pkg and the next_permutation_engine RTL.
`timescale 1ns / 100ps

module tb_next_permutation_engine;
  import npe_pkg::*;

  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  npe_req_t            request = '0;
  logic                result_valid;
  npe_res_t            result;
  logic                cfg_we = 1'b0;
  logic [LEN_BITS-1:0] cfg_data = '0;

  elem_t               perm_elems [MAX_LENGTH];
  logic [LEN_BITS-1:0] length_sel = LEN_RESET[LEN_BITS-1:0];
  npe_res_t            pending_results [$];
  npe_res_t            want;
  int                  idle_pct = 0;
  int                  errors = 0;
  int                  n_requests = 0;
  int                  n_advances = 0;
  int                  n_checked = 0;
  int                  cycle_count = 0;

  next_permutation_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // successor of the multiset sequence, then one result per element in use
  function automatic void predict_successor(npe_req_t req);
    int n, cnt, piv, succ, lo, hi;
    bit moved;
    elem_t t;
    npe_res_t r;
    if (req.cmd == CMD_LOAD) begin
      perm_elems[req.position] = req.value;
      return;
    end
    n = (length_sel > MAX_LENGTH) ? MAX_LENGTH : int'(length_sel);
    moved = 1'b0;
    if (n > 0) begin
      piv = n - 1;
      while (piv > 0 && perm_elems[piv-1] >= perm_elems[piv]) piv--;
      if (piv > 0) begin
        succ = n - 1;
        while (succ > piv && perm_elems[succ] <= perm_elems[piv-1]) succ--;
        t = perm_elems[piv-1];
        perm_elems[piv-1] = perm_elems[succ];
        perm_elems[succ] = t;
        lo = piv;
        hi = n - 1;
        while (lo < hi) begin
          t = perm_elems[lo];
          perm_elems[lo] = perm_elems[hi];
          perm_elems[hi] = t;
          lo++;
          hi--;
        end
        moved = 1'b1;
      end
    end
    cnt = (n > MAX_RESULTS) ? MAX_RESULTS : n;
    for (int k = 0; k < cnt; k++) begin
      r.out_position = k[POS_BITS-1:0];
      r.out_value    = perm_elems[k];
      r.advanced     = moved;
      r.last         = (k == cnt - 1);
      pending_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: out_position %0d out_value %0d",
               result.out_position, result.out_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result.out_position !== want.out_position) begin
          $error("out_position: expected %0d, got %0d", want.out_position,
                 result.out_position);
          errors++;
        end
        if (result.out_value !== want.out_value) begin
          $error("out_value: expected %0d, got %0d", want.out_value, result.out_value);
          errors++;
        end
        if (result.advanced !== want.advanced) begin
          $error("advanced: expected %0d, got %0d", want.advanced, result.advanced);
          errors++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          errors++;
        end
      end
    end
  end

  // start is left high after acceptance so back-to-back requests need no toggle
  task automatic send_request(input npe_req_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_successor(req);
    n_requests++;
    if (req.cmd == CMD_ADVANCE) n_advances++;
  endtask

  task automatic load_elem(input int pos, input int val);
    npe_req_t req;
    req.cmd      = CMD_LOAD;
    req.position = pos[POS_BITS-1:0];
    req.value    = val[OUT_VALUE_BITS-1:0];
    send_request(req);
  endtask

  task automatic advance_seq();
    npe_req_t req;
    req.cmd      = CMD_ADVANCE;
    req.position = 4'($urandom_range(15));
    req.value    = 8'($urandom_range(255));
    send_request(req);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input int len);
    cfg_we   <= 1'b1;
    cfg_data <= len[LEN_BITS-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    length_sel = len[LEN_BITS-1:0];
  endtask

  task automatic test_edge_cases();
    idle_pct = 0;
    write_length(16);
    // descending fill: already the last permutation
    for (int i = 0; i < MAX_LENGTH; i++) load_elem(i, (i == 0) ? 255 : 255 - 17 * i);
    advance_seq();
    wait_idle();
    write_length(0);
    advance_seq();
    wait_idle();
    write_length(1);
    advance_seq();
    wait_idle();
    write_length(31);
    advance_seq();
    load_elem(15, 255);
    advance_seq();
    advance_seq();
    wait_idle();
  endtask

  task automatic test_random_walks(input int gap_pct);
    int len, n;
    bit narrow;
    idle_pct = gap_pct;
    for (int blk = 0; blk < 5; blk++) begin
      wait_idle();
      case ($urandom_range(7))
        0:       len = $urandom_range(1);
        1:       len = 16;
        2:       len = 17 + $urandom_range(14);
        default: len = 2 + $urandom_range(5);
      endcase
      write_length(len);
      n = (len > MAX_LENGTH) ? MAX_LENGTH : len;
      narrow = $urandom_range(2) != 0;
      // few distinct values give long multiset walks that reach the last permutation
      if (narrow) begin
        for (int i = 0; i < n; i++) load_elem(i, $urandom_range(3));
      end
      repeat (13) begin
        if ($urandom_range(4) == 0) begin
          load_elem($urandom_range(15), narrow ? $urandom_range(3) : $urandom_range(255));
        end else begin
          advance_seq();
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_cases();
    test_random_walks(0);
    test_random_walks(88);
    test_random_walks(30);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("Sent %0d requests (%0d advances) over lengths 0 to 31 and three idle mixes",
             n_requests, n_advances);
    $display("Checked %0d results, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[next_permutation_engine.f]
+incdir+rtl
rtl/npe_pkg.sv
rtl/npe_datapath.sv
rtl/npe_ctrl.sv
rtl/next_permutation_engine.sv
rtl/npe_checker.sv
tb/tb_next_permutation_engine.sv
